// File: sv/gsa_pkg.sv
// gsa_pkg: sizes, codes and row types for the generalized suffix automaton
// no dependencies; imported by generalized_suffix_automaton_top, gsa_checker and the testbench
`default_nettype none

package gsa_pkg;

    localparam int STATE_COUNT = 16384;
    localparam int ID_W        = $clog2(STATE_COUNT);
    localparam int CNT_W       = $clog2(STATE_COUNT + 1);
    localparam int FIELD_W     = 14;
    localparam int LEN_W       = 14;
    localparam int SYM_W       = 2;
    localparam int SYM_COUNT   = 4;
    localparam int STATUS_W    = 2;

    typedef logic [ID_W-1:0]               id_t;
    typedef logic [LEN_W-1:0]              len_t;
    typedef logic [CNT_W-1:0]              cnt_t;
    typedef id_t  [SYM_COUNT-1:0]          trans_row_t;

    localparam id_t NULL_ID = id_t'(0);
    localparam id_t ROOT_ID = id_t'(1);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_TRANS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

endpackage

`default_nettype wire

// File: sv/generalized_suffix_automaton_top.sv
// generalized_suffix_automaton_top: sequencer and state stores of the automaton
// depends on gsa_pkg
`default_nettype none

// Builds a suffix automaton over a 2-bit base alphabet and answers transition
// queries, one request at a time; req_stall stays high while a request is in
// work. Transitions, suffix links and lengths sit in three single-port
// memories that share one address, each read registered, so every step of the
// sequencer is at most one memory access. A query reads the row and checks the
// lane. An insert walks suffix links, adding the new transition, and reads the
// existing target when the walk stops on one; a clone then redirects the
// transitions that point at it. A refused insert (full) goes to the response.
// The response register is loaded last. After reset a clearing pass over all
// STATE_COUNT entries (16384) zeroes the stores, during which no request is
// taken. A response waiting in the output register does not stop the next
// request from being taken.
module generalized_suffix_automaton_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic                          kind,
    input  wire logic [gsa_pkg::SYM_W-1:0]     symbol,
    input  wire logic [gsa_pkg::FIELD_W-1:0]   from_state,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [gsa_pkg::FIELD_W-1:0]        result_state,
    output logic [gsa_pkg::STATUS_W-1:0]       status
);
    import gsa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_QCHK,
        S_LENW,
        S_W1RD,
        S_W1CHK,
        S_XRD,
        S_XCHK,
        S_W2RD,
        S_W2CHK,
        S_F1,
        S_F2,
        S_F3,
        S_RESP
    } state_t;

    state_t                 state_reg;
    id_t                    clr_reg;
    id_t                    su_reg;
    id_t                    p_reg;
    id_t                    nz_reg;
    id_t                    x_reg;
    id_t                    clone_reg;
    id_t                    slx_reg;
    len_t                   lp1_reg;
    logic [SYM_W-1:0]       sym_reg;
    cnt_t                   steps_reg;
    id_t                    res_reg;
    logic [STATUS_W-1:0]    stat_reg;
    logic                   rsp_valid_reg;
    logic [FIELD_W-1:0]     result_state_reg;
    logic [STATUS_W-1:0]    status_reg;

    trans_row_t             trans_mem [STATE_COUNT];
    id_t                    slink_mem [STATE_COUNT];
    len_t                   len_mem   [STATE_COUNT];
    trans_row_t             trans_rdata;
    id_t                    slink_rdata;
    len_t                   len_rdata;

    id_t                    mem_addr;
    logic                   mem_re;
    logic                   tr_we_row;
    trans_row_t             tr_row_data;
    logic                   tr_we_lane;
    id_t                    tr_lane_data;
    logic                   sl_we;
    id_t                    sl_data;
    logic                   ln_we;
    len_t                   ln_data;

    logic                   req_take;
    logic                   from_oob;
    id_t                    from_id;
    logic                   is_full;
    id_t                    lane_q;
    logic                   steps_ok;
    logic                   rsp_free;
    len_t                   len_p;

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign from_oob  = (32'(from_state) >= STATE_COUNT);
    assign from_id   = from_oob ? NULL_ID : id_t'(from_state);
    assign is_full   = (32'(su_reg) + 32'd3 > STATE_COUNT);
    assign lane_q    = trans_rdata[sym_reg];
    assign steps_ok  = (32'(steps_reg) < STATE_COUNT);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    // parent equal to the new state: its length was read before it was written
    assign len_p     = (p_reg == nz_reg && steps_reg == '0) ? len_rdata + len_t'(1)
                                                            : len_rdata;

    assign rsp_valid    = rsp_valid_reg;
    assign result_state = result_state_reg;
    assign status       = status_reg;

    // memory port control
    always_comb
    begin
        mem_addr     = p_reg;
        mem_re       = 1'b0;
        tr_we_row    = 1'b0;
        tr_row_data  = trans_rdata;
        tr_we_lane   = 1'b0;
        tr_lane_data = nz_reg;
        sl_we        = 1'b0;
        sl_data      = clone_reg;
        ln_we        = 1'b0;
        ln_data      = lp1_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_addr    = clr_reg;
                tr_we_row   = 1'b1;
                tr_row_data = '0;
                sl_we       = 1'b1;
                sl_data     = NULL_ID;
                ln_we       = 1'b1;
                ln_data     = '0;
            end
            S_IDLE:
            begin
                mem_addr = from_id;
                mem_re   = req_take;
            end
            S_LENW:
            begin
                mem_addr = nz_reg;
                ln_we    = 1'b1;
                ln_data  = len_rdata + len_t'(1);
            end
            S_W1RD, S_W2RD:
            begin
                mem_addr = p_reg;
                mem_re   = 1'b1;
            end
            S_W1CHK:
            begin
                if (p_reg != NULL_ID && lane_q == NULL_ID && steps_ok)
                begin
                    mem_addr     = p_reg;
                    tr_we_lane   = 1'b1;
                    tr_lane_data = nz_reg;
                end
                else if (p_reg == NULL_ID || lane_q == NULL_ID)
                begin
                    mem_addr = nz_reg;
                    sl_we    = 1'b1;
                    sl_data  = ROOT_ID;
                end
            end
            S_XRD:
            begin
                mem_addr = x_reg;
                mem_re   = 1'b1;
            end
            S_XCHK:
            begin
                if (lp1_reg == len_rdata)
                begin
                    mem_addr = nz_reg;
                    sl_we    = 1'b1;
                    sl_data  = x_reg;
                end
                else
                begin
                    mem_addr    = nz_reg + id_t'(1);
                    tr_we_row   = 1'b1;
                    tr_row_data = trans_rdata;
                    ln_we       = 1'b1;
                    ln_data     = lp1_reg;
                end
            end
            S_W2CHK:
            begin
                if (p_reg != NULL_ID && lane_q == x_reg && steps_ok)
                begin
                    mem_addr     = p_reg;
                    tr_we_lane   = 1'b1;
                    tr_lane_data = clone_reg;
                end
            end
            S_F1:
            begin
                mem_addr = clone_reg;
                sl_we    = 1'b1;
                sl_data  = slx_reg;
            end
            S_F2:
            begin
                mem_addr = x_reg;
                sl_we    = 1'b1;
                sl_data  = clone_reg;
            end
            S_F3:
            begin
                mem_addr = nz_reg;
                sl_we    = 1'b1;
                sl_data  = clone_reg;
            end
            S_QCHK, S_RESP:
            begin
                mem_addr = p_reg;
            end
            default:
            begin
                mem_addr = p_reg;
            end
        endcase
    end

    // state stores
    always_ff @(posedge clk)
    begin
        if (tr_we_row)
        begin
            trans_mem[mem_addr] <= tr_row_data;
        end
        else if (tr_we_lane)
        begin
            trans_mem[mem_addr][sym_reg] <= tr_lane_data;
        end
        if (mem_re)
        begin
            trans_rdata <= trans_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sl_we)
        begin
            slink_mem[mem_addr] <= sl_data;
        end
        if (mem_re)
        begin
            slink_rdata <= slink_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ln_we)
        begin
            len_mem[mem_addr] <= ln_data;
        end
        if (mem_re)
        begin
            len_rdata <= len_mem[mem_addr];
        end
    end

    // sequencer and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= NULL_ID;
            su_reg        <= ROOT_ID;
            rsp_valid_reg <= 1'b0;
            steps_reg     <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && state_reg != S_RESP)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + id_t'(1);
                    if (32'(clr_reg) == STATE_COUNT - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_take)
                    begin
                        sym_reg   <= symbol;
                        p_reg     <= from_id;
                        steps_reg <= '0;
                        if (kind == KIND_QUERY)
                        begin
                            if (from_oob)
                            begin
                                res_reg   <= NULL_ID;
                                stat_reg  <= STATUS_NO_TRANS;
                                state_reg <= S_RESP;
                            end
                            else
                            begin
                                state_reg <= S_QCHK;
                            end
                        end
                        else if (is_full)
                        begin
                            res_reg   <= NULL_ID;
                            stat_reg  <= STATUS_FULL;
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            nz_reg    <= su_reg + id_t'(1);
                            su_reg    <= su_reg + id_t'(1);
                            state_reg <= S_LENW;
                        end
                    end
                end
                S_QCHK:
                begin
                    res_reg   <= lane_q;
                    stat_reg  <= (lane_q != NULL_ID) ? STATUS_OK : STATUS_NO_TRANS;
                    state_reg <= S_RESP;
                end
                S_LENW:
                begin
                    state_reg <= S_W1CHK;
                end
                S_W1RD:
                begin
                    state_reg <= S_W1CHK;
                end
                S_W1CHK:
                begin
                    if (p_reg != NULL_ID && lane_q == NULL_ID && steps_ok)
                    begin
                        p_reg     <= slink_rdata;
                        steps_reg <= steps_reg + cnt_t'(1);
                        state_reg <= S_W1RD;
                    end
                    else if (p_reg == NULL_ID || lane_q == NULL_ID)
                    begin
                        res_reg   <= nz_reg;
                        stat_reg  <= STATUS_OK;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        x_reg     <= lane_q;
                        lp1_reg   <= len_p + len_t'(1);
                        state_reg <= S_XRD;
                    end
                end
                S_XRD:
                begin
                    state_reg <= S_XCHK;
                end
                S_XCHK:
                begin
                    if (lp1_reg == len_rdata)
                    begin
                        res_reg   <= nz_reg;
                        stat_reg  <= STATUS_OK;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        clone_reg <= nz_reg + id_t'(1);
                        su_reg    <= su_reg + id_t'(1);
                        slx_reg   <= slink_rdata;
                        steps_reg <= '0;
                        state_reg <= S_W2RD;
                    end
                end
                S_W2RD:
                begin
                    state_reg <= S_W2CHK;
                end
                S_W2CHK:
                begin
                    if (p_reg != NULL_ID && lane_q == x_reg && steps_ok)
                    begin
                        p_reg     <= slink_rdata;
                        steps_reg <= steps_reg + cnt_t'(1);
                        state_reg <= S_W2RD;
                    end
                    else
                    begin
                        state_reg <= S_F1;
                    end
                end
                S_F1:
                begin
                    state_reg <= S_F2;
                end
                S_F2:
                begin
                    state_reg <= S_F3;
                end
                S_F3:
                begin
                    res_reg   <= nz_reg;
                    stat_reg  <= STATUS_OK;
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg    <= 1'b1;
                        result_state_reg <= FIELD_W'(res_reg);
                        status_reg       <= stat_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/gsa_checker.sv
// gsa_checker: port-level checks on generalized_suffix_automaton_top, bound in below
// depends on gsa_pkg and generalized_suffix_automaton_top
`default_nettype none

module gsa_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic                          req_stall,
    input  wire logic                          kind,
    input  wire logic [gsa_pkg::SYM_W-1:0]     symbol,
    input  wire logic [gsa_pkg::FIELD_W-1:0]   from_state,
    input  wire logic                          rsp_valid,
    input  wire logic                          rsp_stall,
    input  wire logic [gsa_pkg::FIELD_W-1:0]   result_state,
    input  wire logic [gsa_pkg::STATUS_W-1:0]  status
);
    import gsa_pkg::*;

    // response held while stalled
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(result_state) && $stable(status))
        else $error("response dropped or changed while stalled");

    // one request at a time
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one still in work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == STATUS_OK || status == STATUS_NO_TRANS
                       || status == STATUS_FULL))
        else $error("undefined status code");

    // failed transfers carry no state id
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STATUS_OK |-> result_state == '0)
        else $error("failed response carries a state id");

    // a successful result is never the null state
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STATUS_OK |-> result_state != '0)
        else $error("successful response carries the null state");

endmodule

bind generalized_suffix_automaton_top gsa_checker u_gsa_checker (.*);

`default_nettype wire

// File: test/tb_generalized_suffix_automaton_top.sv
// testbench for generalized_suffix_automaton_top: directed and random stimulus
// a scoreboard class mirrors the automaton stores and checks every response in order
// depends on gsa_pkg and the block under test
`timescale 1ns / 100ps

module tb_generalized_suffix_automaton_top;
    import gsa_pkg::*;

    localparam int STALL_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1900;

    typedef struct {
        logic [FIELD_W-1:0]  result_state;
        logic [STATUS_W-1:0] status;
    } answer_t;

    class automaton_scoreboard;
        id_t     trans_tab [STATE_COUNT][SYM_COUNT];
        id_t     link_tab  [STATE_COUNT];
        len_t    len_tab   [STATE_COUNT];
        int      used;
        answer_t awaited [$];
        int      inserts;
        int      queries;
        int      refused;
        int      clones;
        int      mismatches;

        function new();
            for (int i = 0; i < STATE_COUNT; i++)
            begin
                for (int s = 0; s < SYM_COUNT; s++)
                begin
                    trans_tab[i][s] = NULL_ID;
                end
                link_tab[i] = NULL_ID;
                len_tab[i]  = '0;
            end
            used       = 1;
            inserts    = 0;
            queries    = 0;
            refused    = 0;
            clones     = 0;
            mismatches = 0;
        endfunction

        // append one symbol after parent, cloning where lengths disagree
        function id_t grow_automaton(logic [SYM_W-1:0] sym, id_t parent);
            id_t  nz;
            id_t  cl;
            id_t  p;
            id_t  x;
            len_t next_len;
            int   steps;
            used++;
            nz          = id_t'(used);
            next_len    = len_tab[parent] + 1'b1;
            len_tab[nz] = next_len;
            p           = parent;
            steps       = 0;
            while (p != NULL_ID && trans_tab[p][sym] == NULL_ID && steps < STATE_COUNT)
            begin
                trans_tab[p][sym] = nz;
                p = link_tab[p];
                steps++;
            end
            if (p == NULL_ID || trans_tab[p][sym] == NULL_ID)
            begin
                link_tab[nz] = ROOT_ID;
                return nz;
            end
            x        = trans_tab[p][sym];
            next_len = len_tab[p] + 1'b1;
            if (next_len == len_tab[x])
            begin
                link_tab[nz] = x;
                return nz;
            end
            used++;
            clones++;
            cl          = id_t'(used);
            len_tab[cl] = next_len;
            for (int s = 0; s < SYM_COUNT; s++)
            begin
                trans_tab[cl][s] = trans_tab[x][s];
            end
            steps = 0;
            while (p != NULL_ID && trans_tab[p][sym] == x && steps < STATE_COUNT)
            begin
                trans_tab[p][sym] = cl;
                p = link_tab[p];
                steps++;
            end
            link_tab[cl] = link_tab[x];
            link_tab[x]  = cl;
            link_tab[nz] = cl;
            return nz;
        endfunction

        function answer_t note_request(logic k, logic [SYM_W-1:0] sym,
                                       logic [FIELD_W-1:0] from);
            answer_t a;
            a.result_state = '0;
            a.status       = STATUS_OK;
            if (k == KIND_INSERT)
            begin
                inserts++;
                if (used + 2 > STATE_COUNT - 1)
                begin
                    refused++;
                    a.status = STATUS_FULL;
                end
                else
                begin
                    a.result_state = grow_automaton(sym, id_t'(from));
                end
            end
            else
            begin
                queries++;
                if (trans_tab[from][sym] != NULL_ID)
                    a.result_state = trans_tab[from][sym];
                else
                    a.status = STATUS_NO_TRANS;
            end
            awaited = {awaited, a};
            return a;
        endfunction

        function void check_response(logic [FIELD_W-1:0] res, logic [STATUS_W-1:0] st);
            answer_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response with nothing outstanding: state %0d status %0d",
                             res, st);
                return;
            end
            want = awaited.pop_front();
            if (res !== want.result_state || st !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected state %0d status %0d, got state %0d status %0d",
                             want.result_state, want.status, res, st);
            end
        endfunction
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                req_valid  = 1'b0;
    logic                req_stall;
    logic                kind       = KIND_INSERT;
    logic [SYM_W-1:0]    symbol     = '0;
    logic [FIELD_W-1:0]  from_state = '0;
    logic                rsp_valid;
    logic                rsp_stall  = 1'b0;
    logic [FIELD_W-1:0]  result_state;
    logic [STATUS_W-1:0] status;

    automaton_scoreboard sb;
    id_t                 known_ids [$];
    bit                  calm = 1'b0;
    int                  idle_cycles = 0;

    generalized_suffix_automaton_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .symbol       (symbol),
        .from_state   (from_state),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .result_state (result_state),
        .status       (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic id_t pick_known();
        int n;
        n = known_ids.size();
        if ($urandom_range(0, 1) == 0)
            return known_ids[n - 1 - $urandom_range(0, (n > 8) ? 7 : n - 1)];
        return known_ids[$urandom_range(0, n - 1)];
    endfunction

    task automatic send_request(input logic k, input logic [SYM_W-1:0] sym,
                                input logic [FIELD_W-1:0] from, output answer_t predicted);
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        kind       <= k;
        symbol     <= sym;
        from_state <= from;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        predicted = sb.note_request(k, sym, from);
        if (k == KIND_INSERT && predicted.status == STATUS_OK)
            known_ids = {known_ids, id_t'(predicted.result_state)};
    endtask

    // receiver side
    initial
    begin
        forever
        begin
            @(posedge clk);
            rsp_stall <= !calm && ($urandom_range(0, 99) < 11);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0)
            sb.check_response(result_state, status);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        answer_t got;
        id_t     last;
        int      r;
        sb = new();
        known_ids = {known_ids, ROOT_ID};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty root, a repetitive string to force clones, odd parents
        send_request(KIND_QUERY, 2'd0, FIELD_W'(ROOT_ID), got);
        last = ROOT_ID;
        for (int i = 0; i < 7; i++)
        begin
            send_request(KIND_INSERT, (i % 3 == 0) ? 2'd0 : 2'd1, FIELD_W'(last), got);
            last = id_t'(got.result_state);
        end
        send_request(KIND_INSERT, 2'd2, FIELD_W'(ROOT_ID), got);
        send_request(KIND_INSERT, 2'd3, FIELD_W'(ROOT_ID), got);
        send_request(KIND_INSERT, 2'd1, FIELD_W'(ROOT_ID), got);
        send_request(KIND_INSERT, 2'd0, FIELD_W'(NULL_ID), got);
        send_request(KIND_INSERT, 2'd3, {FIELD_W{1'b1}}, got);
        for (int s = 0; s < SYM_COUNT; s++)
        begin
            send_request(KIND_QUERY, SYM_W'(s), FIELD_W'(ROOT_ID), got);
        end
        send_request(KIND_QUERY, 2'd3, FIELD_W'(NULL_ID), got);
        send_request(KIND_QUERY, 2'd3, {FIELD_W{1'b1}}, got);
        send_request(KIND_QUERY, 2'd0, {FIELD_W{1'b1}}, got);
        send_request(KIND_QUERY, 2'd1, FIELD_W'(last), got);

        // random: mostly growth from known states and walks over them
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 700 && i < 1100);
            r = $urandom_range(0, 99);
            if (r < 48)
                send_request(KIND_INSERT, SYM_W'($urandom), FIELD_W'(pick_known()), got);
            else if (r < 82)
                send_request(KIND_QUERY, SYM_W'($urandom), FIELD_W'(pick_known()), got);
            else if (r < 94)
                send_request(KIND_QUERY, SYM_W'($urandom),
                             FIELD_W'($urandom_range(0, STATE_COUNT - 1)), got);
            else if (r < 97)
                send_request(KIND_INSERT, SYM_W'($urandom), FIELD_W'(NULL_ID), got);
            else
                send_request(KIND_INSERT, SYM_W'($urandom),
                             FIELD_W'($urandom_range(0, STATE_COUNT - 1)), got);
        end

        calm = 1'b0;
        send_request(KIND_INSERT, 2'd0, FIELD_W'(NULL_ID), got);
        send_request(KIND_INSERT, 2'd3, {FIELD_W{1'b1}}, got);
        send_request(KIND_INSERT, 2'd1, FIELD_W'(ROOT_ID), got);
        send_request(KIND_INSERT, SYM_W'($urandom), FIELD_W'(pick_known()), got);
        for (int i = 0; i < 20; i++)
        begin
            if (i % 2 == 0)
                send_request(KIND_QUERY, SYM_W'($urandom), FIELD_W'(pick_known()), got);
            else
                send_request(KIND_QUERY, SYM_W'($urandom),
                             FIELD_W'(STATE_COUNT - 1 - $urandom_range(0, 3)), got);
        end
        req_valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d inserts (%0d clones, %0d refused as full) and %0d queries",
                 sb.inserts, sb.clones, sb.refused, sb.queries);
        $display("states in use at the end: %0d, mismatches: %0d", sb.used, sb.mismatches);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
